>>> rtl/rfb_pkg.sv
// Package for the radial focus blend block: widths, register indexes,
// zone codes and the item structs. No dependencies.
package rfb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COORD_IN_W     = 12;
    localparam int COORD_MAX_W    = 16;
    localparam int RAD_W          = 13;
    localparam int PIX_W          = 32;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 4;
    localparam int PROD_W         = CH_W + RAD_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 2'd3;

    typedef enum logic [1:0] {
        ZONE_INNER = 2'd0,
        ZONE_RING  = 2'd1,
        ZONE_OUTER = 2'd2
    } t_zone;

    typedef struct packed {
        logic [COORD_IN_W-1:0] pixel_col;
        logic [COORD_IN_W-1:0] pixel_row;
        logic [PIX_W-1:0]      blur_pixel;
        logic [PIX_W-1:0]      orig_pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [1:0]       zone;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0] blur;
        logic [PIX_W-1:0] orig;
    } t_side;

endpackage

>>> rtl/rfb_radius.sv
// Radius pipeline: absolute differences, squares, sum, then one root bit
// per stage (restoring square root). Depends on rfb_pkg.
module rfb_radius #(
    parameter int COORD_BITS = rfb_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_center_col,
    input  logic [COORD_BITS-1:0] i_center_row,
    input  rfb_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [COORD_BITS:0]   o_radius,
    output rfb_pkg::t_side        o_side
);
    import rfb_pkg::*;

    localparam int RB  = COORD_BITS + 1;
    localparam int RW  = 2 * RB;
    localparam int RMW = RB + 3;
    localparam int SQW = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic                  r_v1, r_v2;
    t_side                 r_sd1, r_sd2;
    logic [SQW-1:0]        r_sqx, r_sqy;

    logic [RW-1:0]  r_rad  [0:RB];
    logic [RMW-1:0] r_rem  [0:RB];
    logic [RB-1:0]  r_root [0:RB];
    logic           r_v    [0:RB];
    t_side          r_sd   [0:RB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= (i_col >= i_center_col) ? i_col - i_center_col : i_center_col - i_col;
            r_dy  <= (i_row >= i_center_row) ? i_row - i_center_row : i_center_row - i_row;
            r_sd1 <= i_side;
            r_sqx <= SQW'(r_dx) * SQW'(r_dx);
            r_sqy <= SQW'(r_dy) * SQW'(r_dy);
            r_sd2 <= r_sd1;
            r_rad[0]  <= RW'(r_sqx) + RW'(r_sqy);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sd[0]   <= r_sd2;
        end
    end

    for (genvar s = 1; s <= RB; s++) begin : g_root
        logic [RMW-1:0] cat, trial;
        logic           ge;

        assign cat   = {r_rem[s-1][RMW-3:0], r_rad[s-1][RW-1:RW-2]};
        assign trial = {1'b0, r_root[s-1], 2'b01};
        assign ge    = cat >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? cat - trial : cat;
                r_root[s] <= {r_root[s-1][RB-2:0], ge};
                r_rad[s]  <= {r_rad[s-1][RW-3:0], 2'b00};
                r_sd[s]   <= r_sd[s-1];
            end
        end
    end

    assign o_valid  = r_v[RB];
    assign o_radius = r_root[RB];
    assign o_side   = r_sd[RB];

endmodule

>>> rtl/rfb_blend.sv
// Blend pipeline: zone decision, channel products, one quotient bit per
// stage for all eight divisions, then the output register. Depends on rfb_pkg.
module rfb_blend #(
    parameter int COORD_BITS = rfb_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [COORD_BITS:0]           i_radius,
    input  logic [rfb_pkg::RAD_W-1:0]     i_inner,
    input  logic [rfb_pkg::RAD_W-1:0]     i_outer,
    input  rfb_pkg::t_side                i_side,
    output logic                          o_valid,
    output rfb_pkg::t_out_item            o_item
);
    import rfb_pkg::*;

    localparam int RB  = COORD_BITS + 1;
    localparam int CW  = (RB > RAD_W) ? RB : RAD_W;
    localparam int NST = CH_W;

    logic [CW-1:0] rad_x, in_x, out_x;
    t_zone         zone_n;

    assign rad_x = CW'(i_radius);
    assign in_x  = CW'(i_inner);
    assign out_x = CW'(i_outer);

    always_comb begin
        if (rad_x < in_x) begin
            zone_n = ZONE_INNER;
        end else if (rad_x < out_x) begin
            zone_n = ZONE_RING;
        end else begin
            zone_n = ZONE_OUTER;
        end
    end

    logic             r_v1;
    t_zone            r_zn1;
    logic [RAD_W-1:0] r_k, r_d1;
    t_side            r_sd1;

    logic [PROD_W-1:0] r_rb [0:NST][0:NUM_CH-1];
    logic [PROD_W-1:0] r_ro [0:NST][0:NUM_CH-1];
    logic [CH_W-1:0]   r_qb [0:NST][0:NUM_CH-1];
    logic [CH_W-1:0]   r_qo [0:NST][0:NUM_CH-1];
    logic [RAD_W-1:0]  r_dv [0:NST];
    t_zone             r_zn [0:NST];
    t_side             r_sd [0:NST];
    logic              r_vb [0:NST];

    logic      r_vo;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_vb[0] <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_vb[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zn1   <= zone_n;
            r_k     <= RAD_W'(i_radius) - i_inner;
            r_d1    <= i_outer - i_inner;
            r_sd1   <= i_side;
            r_dv[0] <= r_d1;
            r_zn[0] <= r_zn1;
            r_sd[0] <= r_sd1;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rb[0][c] <= PROD_W'(r_sd1.blur[CH_W*c +: CH_W]) * PROD_W'(r_k);
                r_ro[0][c] <= PROD_W'(r_sd1.orig[CH_W*c +: CH_W]) * PROD_W'(r_d1 - r_k);
                r_qb[0][c] <= '0;
                r_qo[0][c] <= '0;
            end
        end
    end

    for (genvar s = 1; s <= NST; s++) begin : g_div
        logic [PROD_W-1:0] dsh;

        assign dsh = PROD_W'(r_dv[s-1]) << (NST - s);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vb[s] <= 1'b0;
            end else if (i_en) begin
                r_vb[s] <= r_vb[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[s] <= r_dv[s-1];
                r_zn[s] <= r_zn[s-1];
                r_sd[s] <= r_sd[s-1];
            end
        end

        for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
            logic geb, geo;

            assign geb = r_rb[s-1][c] >= dsh;
            assign geo = r_ro[s-1][c] >= dsh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rb[s][c] <= geb ? r_rb[s-1][c] - dsh : r_rb[s-1][c];
                    r_ro[s][c] <= geo ? r_ro[s-1][c] - dsh : r_ro[s-1][c];
                    r_qb[s][c] <= {r_qb[s-1][c][CH_W-2:0], geb};
                    r_qo[s][c] <= {r_qo[s-1][c][CH_W-2:0], geo};
                end
            end
        end
    end

    logic [PIX_W-1:0] mix;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            mix[CH_W*c +: CH_W] = r_qb[NST][c] + r_qo[NST][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vb[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.zone <= r_zn[NST];
            case (r_zn[NST])
                ZONE_INNER: r_out.out_pixel <= r_sd[NST].orig;
                ZONE_RING:  r_out.out_pixel <= mix;
                default:    r_out.out_pixel <= r_sd[NST].blur;
            endcase
        end
    end

    assign o_valid = r_vo;
    assign o_item  = r_out;

endmodule

>>> rtl/radial_focus_blend_top.sv
// Throughput: one item per cycle; the whole pipeline holds while the output
// item waits, and the input takes an item whenever the pipeline moves.
// Depth is set by one root bit per stage and one quotient bit per stage.
// Reset: synchronous active low, clears valid bits and configuration registers
// to zero; datapath registers are not reset.
module radial_focus_blend_top #(
    parameter int COORD_BITS = rfb_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rfb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rfb_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rfb_pkg::t_out_item               o_out_data
);
    import rfb_pkg::*;

    logic [COORD_IN_W-1:0] r_center_col, r_center_row;
    logic [RAD_W-1:0]      r_inner, r_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col <= '0;
            r_center_row <= '0;
            r_inner      <= '0;
            r_outer      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_COL:   r_center_col <= i_cfg_data[COORD_IN_W-1:0];
                REG_CENTER_ROW:   r_center_row <= i_cfg_data[COORD_IN_W-1:0];
                REG_INNER_RADIUS: r_inner      <= i_cfg_data[RAD_W-1:0];
                REG_OUTER_RADIUS: r_outer      <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic                   en;
    logic [COORD_MAX_W-1:0] ext_col, ext_row, ext_ccol, ext_crow;
    t_side                  side_in, side_mid;
    logic                   v_mid;
    logic [COORD_BITS:0]    radius;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign ext_col  = COORD_MAX_W'(i_in_data.pixel_col);
    assign ext_row  = COORD_MAX_W'(i_in_data.pixel_row);
    assign ext_ccol = COORD_MAX_W'(r_center_col);
    assign ext_crow = COORD_MAX_W'(r_center_row);

    assign side_in.blur = i_in_data.blur_pixel;
    assign side_in.orig = i_in_data.orig_pixel;

    rfb_radius #(.COORD_BITS(COORD_BITS)) u_radius (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_col        (ext_col[COORD_BITS-1:0]),
        .i_row        (ext_row[COORD_BITS-1:0]),
        .i_center_col (ext_ccol[COORD_BITS-1:0]),
        .i_center_row (ext_crow[COORD_BITS-1:0]),
        .i_side       (side_in),
        .o_valid      (v_mid),
        .o_radius     (radius),
        .o_side       (side_mid)
    );

    rfb_blend #(.COORD_BITS(COORD_BITS)) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (v_mid),
        .i_radius (radius),
        .i_inner  (r_inner),
        .i_outer  (r_outer),
        .i_side   (side_mid),
        .o_valid  (o_out_valid),
        .o_item   (o_out_data)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for radial_focus_blend_top: directed and random pixels under
// several idle and stall mixes, checked against an in-bench blend predictor.
// Depends on rfb_pkg and radial_focus_blend_top.
module testbench;
    import rfb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;

    logic [11:0] ctr_col, ctr_row;
    logic [12:0] rad_in, rad_out;
    t_out_item pending_pixels[$];
    int errors = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    always #6 i_clk = ~i_clk;

    radial_focus_blend_top dut (.*);

    function automatic logic [7:0] mix(logic [7:0] b, logic [7:0] o, int k, int d);
        return 8'((b * k) / d + (o * (d - k)) / d);
    endfunction

    function automatic t_out_item blend_pixel(t_in_item it);
        t_out_item res;
        longint dx, dy, sq, r;
        int k, d;
        dx = longint'(it.pixel_col) - longint'(ctr_col);
        dy = longint'(it.pixel_row) - longint'(ctr_row);
        sq = dx * dx + dy * dy;
        r = 0;
        while ((r + 1) * (r + 1) <= sq) r = r + 1;
        if (r < rad_in) begin
            res.out_pixel = it.orig_pixel;
            res.zone = ZONE_INNER;
        end else if (r < rad_out) begin
            k = int'(r) - rad_in;
            d = rad_out - rad_in;
            for (int c = 0; c < 4; c++)
                res.out_pixel[c*8 +: 8] = mix(it.blur_pixel[c*8 +: 8],
                                              it.orig_pixel[c*8 +: 8], k, d);
            res.zone = ZONE_RING;
        end else begin
            res.out_pixel = it.blur_pixel;
            res.zone = ZONE_OUTER;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch: %s at %0t", what, $realtime);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected item");
            end else begin
                t_out_item e;
                e = pending_pixels.pop_front();
                if (o_out_data.out_pixel !== e.out_pixel)
                    report_mismatch($sformatf("pixel %h exp %h", o_out_data.out_pixel,
                                              e.out_pixel));
                if (o_out_data.zone !== e.zone)
                    report_mismatch($sformatf("zone %0d exp %0d", o_out_data.zone, e.zone));
            end
        end
    end

    // valid stays high after acceptance until the next send or drain drops it
    task automatic send_pixel(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        pending_pixels.push_back(blend_pixel(it));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard = 0;
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_CENTER_COL: ctr_col = val[11:0];
            REG_CENTER_ROW: ctr_row = val[11:0];
            REG_INNER_RADIUS: rad_in = val;
            default: rad_out = val;
        endcase
    endtask

    task automatic set_focus(int cc, int cr, int ri, int ro);
        drain();
        write_reg(REG_CENTER_COL, 13'(cc));
        write_reg(REG_CENTER_ROW, 13'(cr));
        write_reg(REG_INNER_RADIUS, 13'(ri));
        write_reg(REG_OUTER_RADIUS, 13'(ro));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item rand_pixel(int cc, int cr, int span);
        t_in_item it;
        int c, r;
        c = cc + $urandom_range(2 * span) - span;
        r = cr + $urandom_range(2 * span) - span;
        if ($urandom_range(9) == 0) begin
            c = $urandom_range(4095);
            r = $urandom_range(4095);
        end
        it.pixel_col = 12'(c < 0 ? 0 : (c > 4095 ? 4095 : c));
        it.pixel_row = 12'(r < 0 ? 0 : (r > 4095 ? 4095 : r));
        it.blur_pixel = $urandom();
        it.orig_pixel = $urandom();
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        set_focus(0, 0, 0, 0);
        it = '{12'd0, 12'd0, 32'hffffffff, 32'h00000000};
        send_pixel(it);
        set_focus(2048, 2048, 10, 100);
        send_pixel('{12'd2048, 12'd2048, 32'h12345678, 32'h9abcdef0});
        send_pixel('{12'd2058, 12'd2048, 32'hffffffff, 32'h00000000});
        send_pixel('{12'd2048, 12'd2147, 32'h00000000, 32'hffffffff});
        send_pixel('{12'd2048, 12'd2148, 32'hffffffff, 32'hffffffff});
        send_pixel('{12'd2000, 12'd2100, 32'hff00ff00, 32'h00ff00ff});
        set_focus(4095, 4095, 8191, 8191);
        send_pixel('{12'd0, 12'd0, 32'haaaaaaaa, 32'h55555555});
        send_pixel('{12'd4095, 12'd4095, 32'h55555555, 32'haaaaaaaa});
        // inner not below outer: empty ring
        set_focus(100, 100, 50, 20);
        send_pixel('{12'd110, 12'd100, 32'h01020304, 32'h05060708});
        send_pixel('{12'd140, 12'd100, 32'h01020304, 32'h05060708});
        send_pixel('{12'd180, 12'd100, 32'h01020304, 32'h05060708});
        set_focus(0, 4095, 0, 8191);
        send_pixel('{12'd4095, 12'd0, 32'hffffffff, 32'h00000000});
        send_pixel('{12'd0, 12'd4095, 32'hffffffff, 32'h00000000});
    endtask

    task automatic test_random(int sidle, int rstall, int n);
        int cc, cr, ri, ro;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cc = $urandom_range(4095);
        cr = $urandom_range(4095);
        ri = $urandom_range(300);
        ro = ri + $urandom_range(1, 400);
        set_focus(cc, cr, ri, ro);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 99) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                ri = $urandom_range(8191);
                ro = ($urandom_range(4) == 0) ? $urandom_range(8191)
                                             : ri + $urandom_range(1, 500);
                if (ro > 8191) ro = 8191;
                set_focus($urandom_range(4095), $urandom_range(4095), ri % 600, ro % 1200);
                cc = ctr_col;
                cr = ctr_row;
                send_idle_pct = sidle;
                recv_stall_pct = rstall;
            end
            send_pixel(rand_pixel(cc, cr, 1 + rad_out + rad_out / 4));
        end
    endtask

    task automatic test_backpressure();
        set_focus(1000, 1000, 20, 60);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_cycles = 200;
        for (int i = 0; i < 100; i++) send_pixel(rand_pixel(1000, 1000, 80));
    endtask

    initial begin
        ctr_col = '0;
        ctr_row = '0;
        rad_in = '0;
        rad_out = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(0, 0, 500);
        test_random(53, 0, 500);
        test_random(0, 53, 500);
        test_random(12, 12, 500);
        test_backpressure();
        drain();
        $display("Covered directed extremes, empty ring, four idle/stall mixes and a long");
        $display("output hold; %0d items checked.", results_seen);
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("** radial_focus_blend_top: PASSED **");
        end else begin
            $display("** radial_focus_blend_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("** radial_focus_blend_top: FAILED **");
        $finish;
    end
endmodule
